// ===== design/fdsp_pkg.sv =====
// ----------------------------------------------------------------------------
// FBMC frequency despreader package
// Shared widths, sample and queue entry types, and the weight table.
// ----------------------------------------------------------------------------
`default_nettype none

package fdsp_pkg;

  localparam int SampleW   = 16;
  localparam int MaxOverlap = 4;
  localparam int WinDepth  = 2 * MaxOverlap - 1;
  localparam int WinIdxW   = $clog2(WinDepth);
  localparam int MaxScLog2 = 8;
  localparam int ScW       = MaxScLog2;
  localparam int LgW       = 4;
  localparam int KW        = 3;
  localparam int KselW     = 2;
  localparam int PhaseW    = $clog2(MaxOverlap);
  localparam int TapW      = $clog2(MaxOverlap);
  localparam int CoefW     = 16;
  localparam int ProdW     = SampleW + 1 + CoefW;
  localparam int SumW      = ProdW + TapW + 1;
  localparam int FracW     = 15;
  localparam int RndW      = SumW - FracW;
  localparam int FifoDepth = 4;
  localparam int FifoPtrW  = $clog2(FifoDepth);
  localparam int FifoCntW  = FifoPtrW + 1;
  localparam int CfgIdxW   = 1;
  localparam int CfgDataW  = 4;
  localparam int OutDataW  = 2 * SampleW + ScW;

  typedef enum logic [CfgIdxW-1:0] {
    CfgOverlap = 1'b0,
    CfgScLog2  = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [SampleW-1:0] im;
    logic [SampleW-1:0] re;
  } cplx_t;

  // One queued sample that causes results: window after the shift, head copy,
  // index of the regular subcarrier and which jobs it carries.
  typedef struct packed {
    cplx_t [WinDepth-1:0]   win;
    cplx_t [MaxOverlap-1:0] head;
    logic [ScW-1:0]         sc;
    logic                   has_norm;
    logic                   has_zero;
  } entry_t;

  // PHYDYAS weights pre-divided by K, Q1.15; ksel = K - 2
  function automatic logic signed [CoefW-1:0] coef(input logic [KselW-1:0] ksel,
                                                   input logic [TapW-1:0] tap);
    logic signed [CoefW-1:0] w;
    w = '0;
    case (ksel)
      2'd0: begin
        case (tap)
          2'd0:    w = 16'sd16384;
          2'd1:    w = 16'sd11585;
          default: w = '0;
        endcase
      end
      2'd1: begin
        case (tap)
          2'd0:    w = 16'sd10923;
          2'd1:    w = 16'sd9955;
          2'd2:    w = 16'sd4494;
          default: w = '0;
        endcase
      end
      default: begin
        case (tap)
          2'd0:    w = 16'sd8192;
          2'd1:    w = 16'sd7962;
          2'd2:    w = 16'sd5793;
          default: w = 16'sd1926;
        endcase
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== design/fbmc_frequency_despreader_unit.sv =====
// ----------------------------------------------------------------------------
// FBMC frequency despreader unit
// Despreads an FBMC symbol vector of M*K samples into M weighted subcarriers.
// ----------------------------------------------------------------------------
// Takes one complex sample per clock with no gaps required while the queue has
// room. Subcarrier i >= 1 leaves once its last sample is in; subcarrier 0
// follows subcarrier M-1 after the vector's final sample, computed from a
// stored copy of the first K samples. A sample that causes results is queued
// (4 entries) together with its window; each queued job then passes the
// registered multiplier stage (eight parallel constant-table multiplies) and
// the registered sum, round and saturate stage. The output side carries one
// result per cycle while the receiver is ready; the final sample of a vector
// with M >= 2 yields two results, which the queue absorbs. Configuration writes
// restart the vector and must only be issued while the unit is idle.
`default_nettype none

module fbmc_frequency_despreader_unit (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // config write channel
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [fdsp_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [fdsp_pkg::CfgDataW-1:0]  cfg_data_i,
  // sample stream
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire logic [2*fdsp_pkg::SampleW-1:0] s_axis_tdata,  // sample_re, sample_im
  // subcarrier stream
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  output logic [fdsp_pkg::OutDataW-1:0]       m_axis_tdata,  // out_re, out_im, subcarrier
  output logic                                m_axis_tlast   // last_of_run
);
  import fdsp_pkg::*;

  localparam logic signed [RndW-1:0] SatMax = RndW'((1 << (SampleW - 1)) - 1);
  localparam logic signed [RndW-1:0] SatMin = -SatMax - RndW'(1);
  localparam logic signed [SumW-1:0] RndHalf = SumW'(1 << (FracW - 1));

  // configuration
  logic [KW-1:0]  k_cfg_q;
  logic [LgW-1:0] lg_cfg_q;
  logic           cfg_acc;

  // input side state
  cplx_t          win_q  [WinDepth];
  cplx_t          head_q [MaxOverlap];
  logic [ScW-1:0]    group_q, group_d;
  logic [PhaseW-1:0] phase_q, phase_d;

  // job queue
  entry_t            fifo_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [FifoCntW-1:0] cnt_q, cnt_d;
  logic              sub_q, sub_d;

  // multiplier stage
  logic signed [ProdW-1:0] prod_re_q [MaxOverlap];
  logic signed [ProdW-1:0] prod_im_q [MaxOverlap];
  logic signed [ProdW-1:0] prod_re_d [MaxOverlap];
  logic signed [ProdW-1:0] prod_im_d [MaxOverlap];
  logic [ScW-1:0]          mul_sc_q;
  logic                    mul_last_q, mul_vld_q;

  // output stage
  logic [SampleW-1:0] out_re_q, out_im_q;
  logic [ScW-1:0]     out_sc_q;
  logic               out_last_q, out_vld_q;

  // derived configuration
  logic [KselW-1:0]  ksel;
  logic [PhaseW-1:0] k_last;
  logic [LgW-1:0]    lg_eff;
  logic [ScW:0]      m_full;
  logic [ScW-1:0]    last_grp;

  always_comb begin
    if (k_cfg_q < KW'(2)) begin
      ksel = '0;
    end else if (k_cfg_q >= KW'(MaxOverlap)) begin
      ksel = KselW'(MaxOverlap - 2);
    end else begin
      ksel = KselW'(k_cfg_q - KW'(2));
    end
    k_last   = PhaseW'(ksel) + PhaseW'(1);
    lg_eff   = (lg_cfg_q > LgW'(MaxScLog2)) ? LgW'(MaxScLog2) : lg_cfg_q;
    m_full   = (ScW+1)'(1) << lg_eff;
    last_grp = ScW'(m_full - (ScW+1)'(1));
  end

  // ---------------- input side ----------------
  logic   in_acc, grp_end, is_final, emit_norm, push;
  cplx_t  smp;
  entry_t new_ent;

  assign cfg_ready_o   = 1'b1;
  assign cfg_acc       = cfg_valid_i && cfg_ready_o;
  assign s_axis_tready = (cnt_q != FifoCntW'(FifoDepth));
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign smp           = s_axis_tdata;

  assign grp_end   = (phase_q == k_last);
  assign is_final  = grp_end && (group_q == last_grp);
  assign emit_norm = grp_end && (group_q != '0);
  assign push      = in_acc && (emit_norm || is_final);

  always_comb begin
    new_ent.win[0] = smp;
    for (int i = 1; i < WinDepth; i++) begin
      new_ent.win[i] = win_q[i-1];
    end
    for (int i = 0; i < MaxOverlap; i++) begin
      new_ent.head[i] = head_q[i];
    end
    if (group_q == '0) begin
      new_ent.head[phase_q] = smp;
    end
    new_ent.sc       = group_q;
    new_ent.has_norm = emit_norm;
    new_ent.has_zero = is_final;
  end

  always_comb begin
    group_d = group_q;
    phase_d = phase_q;
    if (cfg_acc) begin
      group_d = '0;
      phase_d = '0;
    end else if (in_acc) begin
      if (is_final) begin
        group_d = '0;
        phase_d = '0;
      end else if (grp_end) begin
        group_d = group_q + ScW'(1);
        phase_d = '0;
      end else begin
        phase_d = phase_q + PhaseW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_cfg_q  <= KW'(MaxOverlap);
      lg_cfg_q <= LgW'(MaxScLog2);
      group_q  <= '0;
      phase_q  <= '0;
      for (int i = 0; i < WinDepth; i++) begin
        win_q[i] <= '0;
      end
    end else begin
      if (cfg_acc) begin
        case (cfg_idx_e'(cfg_index_i))
          CfgOverlap: k_cfg_q  <= cfg_data_i[KW-1:0];
          CfgScLog2:  lg_cfg_q <= cfg_data_i[LgW-1:0];
          default: ;
        endcase
      end
      group_q <= group_d;
      phase_q <= phase_d;
      if (in_acc) begin
        for (int i = 0; i < WinDepth; i++) begin
          win_q[i] <= new_ent.win[i];
        end
      end
    end
  end

  // head copy is written before subcarrier 0 reads it
  always_ff @(posedge clk_i) begin
    if (in_acc && !cfg_acc) begin
      for (int i = 0; i < MaxOverlap; i++) begin
        head_q[i] <= new_ent.head[i];
      end
    end
  end

  // ---------------- job queue ----------------
  logic   adv_o, adv_m, issue, pop, do_zero;
  entry_t ent;

  assign adv_o   = !out_vld_q || m_axis_tready;
  assign adv_m   = !mul_vld_q || adv_o;
  assign ent     = fifo_q[rd_ptr_q];
  assign issue   = (cnt_q != '0) && adv_m;
  assign do_zero = !ent.has_norm || sub_q;
  assign pop     = issue && (do_zero || !ent.has_zero);

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + FifoCntW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - FifoCntW'(1);
    end
    sub_d = sub_q;
    if (issue) begin
      sub_d = !pop;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
      sub_q    <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + FifoPtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + FifoPtrW'(1);
      end
      cnt_q <= cnt_d;
      sub_q <= sub_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= new_ent;
    end
  end

  // ---------------- operand select and multiply ----------------
  cplx_t ctr;
  cplx_t tap_a [MaxOverlap];
  cplx_t tap_b [MaxOverlap];

  always_comb begin
    for (int j = 0; j < MaxOverlap; j++) begin
      tap_a[j] = '0;
      tap_b[j] = '0;
    end
    if (do_zero) begin
      ctr = ent.head[0];
      // head slots at or above K may never have been written
      for (int j = 1; j < MaxOverlap; j++) begin
        if (j <= int'(ksel) + 1) begin
          tap_a[j] = ent.head[j];
          tap_b[j] = ent.win[j-1];
        end
      end
    end else begin
      ctr = ent.win[WinIdxW'(ksel) + WinIdxW'(1)];
      for (int j = 1; j < MaxOverlap; j++) begin
        if (j <= int'(ksel) + 1) begin
          tap_a[j] = ent.win[WinIdxW'(int'(ksel) + 1 - j)];
          tap_b[j] = ent.win[WinIdxW'(int'(ksel) + 1 + j)];
        end
      end
    end
  end

  always_comb begin
    logic signed [SampleW:0]  pre_re, pre_im;
    logic signed [CoefW-1:0]  w;
    w = coef(ksel, '0);
    prod_re_d[0] = ProdW'($signed(ctr.re)) * ProdW'(w);
    prod_im_d[0] = ProdW'($signed(ctr.im)) * ProdW'(w);
    for (int j = 1; j < MaxOverlap; j++) begin
      w      = coef(ksel, TapW'(j));
      pre_re = (SampleW+1)'($signed(tap_a[j].re)) + (SampleW+1)'($signed(tap_b[j].re));
      pre_im = (SampleW+1)'($signed(tap_a[j].im)) + (SampleW+1)'($signed(tap_b[j].im));
      prod_re_d[j] = ProdW'(pre_re) * ProdW'(w);
      prod_im_d[j] = ProdW'(pre_im) * ProdW'(w);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_vld_q <= 1'b0;
    end else if (adv_m) begin
      mul_vld_q <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      for (int j = 0; j < MaxOverlap; j++) begin
        prod_re_q[j] <= prod_re_d[j];
        prod_im_q[j] <= prod_im_d[j];
      end
      mul_sc_q   <= do_zero ? '0 : ent.sc;
      mul_last_q <= do_zero || !ent.has_zero;
    end
  end

  // ---------------- sum, round half up, saturate ----------------
  function automatic logic [SampleW-1:0] rnd_sat(input logic signed [SumW-1:0] acc);
    logic signed [SumW-1:0] biased;
    logic signed [RndW-1:0] r;
    logic [SampleW-1:0]     res;
    biased = acc + RndHalf;
    r      = RndW'(biased >>> FracW);
    if (r > SatMax) begin
      res = SatMax[SampleW-1:0];
    end else if (r < SatMin) begin
      res = SatMin[SampleW-1:0];
    end else begin
      res = r[SampleW-1:0];
    end
    return res;
  endfunction

  logic signed [SumW-1:0] sum_re, sum_im;

  always_comb begin
    sum_re = '0;
    sum_im = '0;
    for (int j = 0; j < MaxOverlap; j++) begin
      sum_re = sum_re + SumW'(prod_re_q[j]);
      sum_im = sum_im + SumW'(prod_im_q[j]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv_o) begin
      out_vld_q <= mul_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o && mul_vld_q) begin
      out_re_q   <= rnd_sat(sum_re);
      out_im_q   <= rnd_sat(sum_im);
      out_sc_q   <= mul_sc_q;
      out_last_q <= mul_last_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {out_sc_q, out_im_q, out_re_q};
  assign m_axis_tlast  = out_last_q;

  // ---------------- assertions ----------------
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FifoCntW'(FifoDepth))
    else $error("job queue count overflow");

  a_cfg_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_acc |=> (group_q == '0) && (phase_q == '0))
    else $error("config write did not restart the vector");

  a_zero_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (issue && do_zero) |=> mul_vld_q && mul_last_q && (mul_sc_q == '0))
    else $error("subcarrier 0 job lost its index or last flag");

  a_second_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sub_q |-> (cnt_q != '0) && ent.has_norm && ent.has_zero)
    else $error("pending second job without a two-result entry");

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// FBMC frequency despreader unit testbench
// Streams complex samples through the despreader under changing overlap and
// subcarrier-count settings. A behavioral model of the weighting and the
// vector bookkeeping predicts every subcarrier result. The results are then
// checked in order while both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ClkPeriod     = 20;
  localparam int ResetCycles   = 7;
  localparam int IdlePct       = 38;
  localparam int HoldCycles    = 400;
  localparam int SettleCycles  = 10;
  localparam int TimeoutCycles = 200000;
  localparam int RandomSamples = 550;

  // PHYDYAS weights over K, Q1.15, row K-2
  localparam int Weight [3][4] = '{
    '{16384, 11585, 0, 0},
    '{10923, 9955, 4494, 0},
    '{8192, 7962, 5793, 1926}
  };

  typedef struct {
    logic [15:0] re;
    logic [15:0] im;
    logic [7:0]  sc;
    logic        last;
  } subcarrier_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  fdsp_pkg::cfg_idx_e   cfg_index_i = fdsp_pkg::CfgOverlap;
  logic [3:0]           cfg_data_i = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [31:0]          s_axis_tdata = '0;    // sample_re, sample_im
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [39:0]          m_axis_tdata;         // out_re, out_im, subcarrier
  logic                 m_axis_tlast;         // last_of_run

  fbmc_frequency_despreader_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // stimulus and expectations
  logic [31:0]  pending_samples [$];
  subcarrier_t  expected_subcarriers [$];
  bit           calm = 1'b0;
  int           hold_requests = 0;
  int           hold_seen;
  int           hold_left;
  int           samples_accepted = 0;
  int           results_checked = 0;
  int           reg_writes = 0;
  int           mismatches = 0;

  // despreader state as the testbench sees it
  logic [2:0]          cfg_k = 3'd4;
  logic [3:0]          cfg_lg = 4'd8;
  logic signed [15:0]  win_re [7];
  logic signed [15:0]  win_im [7];
  logic signed [15:0]  head_re [4];
  logic signed [15:0]  head_im [4];
  int                  sample_pos = 0;

  initial begin
    for (int i = 0; i < 7; i++) begin
      win_re[i] = '0;
      win_im[i] = '0;
    end
    for (int i = 0; i < 4; i++) begin
      head_re[i] = '0;
      head_im[i] = '0;
    end
  end

  initial begin
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  function automatic int eff_overlap();
    if (cfg_k < 3'd2) return 2;
    if (cfg_k > 3'd4) return 4;
    return int'(cfg_k);
  endfunction

  function automatic int eff_lg();
    return (cfg_lg > 4'd8) ? 8 : int'(cfg_lg);
  endfunction

  function automatic logic [15:0] round_sat(longint acc);
    longint r;
    r = (acc + 64'sd16384) >>> 15;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  function automatic logic [15:0] weigh(int k, longint c, longint a[4], longint b[4]);
    longint acc;
    acc = Weight[k-2][0] * c;
    for (int j = 1; j < k; j++) acc += Weight[k-2][j] * (a[j] + b[j]);
    return round_sat(acc);
  endfunction

  // subcarrier centered on window tap k-1
  task automatic expect_interior_subcarrier(int k, int sc, logic last);
    longint       a_re [4];
    longint       a_im [4];
    longint       b_re [4];
    longint       b_im [4];
    subcarrier_t  res;
    for (int j = 0; j < 4; j++) begin
      a_re[j] = 0; a_im[j] = 0; b_re[j] = 0; b_im[j] = 0;
    end
    for (int j = 1; j < k; j++) begin
      a_re[j] = win_re[k-1-j];
      a_im[j] = win_im[k-1-j];
      b_re[j] = win_re[k-1+j];
      b_im[j] = win_im[k-1+j];
    end
    res.re = weigh(k, win_re[k-1], a_re, b_re);
    res.im = weigh(k, win_im[k-1], a_im, b_im);
    res.sc = sc[7:0];
    res.last = last;
    expected_subcarriers.push_back(res);
  endtask

  task automatic despread_sample(logic [31:0] data);
    int           k;
    int           m;
    int           total;
    int           p;
    longint       a_re [4];
    longint       a_im [4];
    longint       b_re [4];
    longint       b_im [4];
    subcarrier_t  res;
    k = eff_overlap();
    m = 1 << eff_lg();
    total = m * k;
    p = (sample_pos >= total) ? 0 : sample_pos;
    if (p < k) begin
      head_re[p] = data[15:0];
      head_im[p] = data[31:16];
    end
    for (int i = 6; i > 0; i--) begin
      win_re[i] = win_re[i-1];
      win_im[i] = win_im[i-1];
    end
    win_re[0] = data[15:0];
    win_im[0] = data[31:16];
    if (p == total - 1) begin
      if (m >= 2) expect_interior_subcarrier(k, m - 1, 1'b0);
      // subcarrier 0 wraps around to the saved head of the vector
      for (int j = 0; j < 4; j++) begin
        a_re[j] = 0; a_im[j] = 0; b_re[j] = 0; b_im[j] = 0;
      end
      for (int j = 1; j < k; j++) begin
        a_re[j] = head_re[j];
        a_im[j] = head_im[j];
        b_re[j] = win_re[j-1];
        b_im[j] = win_im[j-1];
      end
      res.re = weigh(k, head_re[0], a_re, b_re);
      res.im = weigh(k, head_im[0], a_im, b_im);
      res.sc = 8'd0;
      res.last = 1'b1;
      expected_subcarriers.push_back(res);
      sample_pos = 0;
    end else begin
      if ((p + 1) % k == 0 && p + 1 >= 2 * k) expect_interior_subcarrier(k, (p + 1) / k - 1, 1'b1);
      sample_pos = p + 1;
    end
  endtask

  // sample driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        despread_sample(s_axis_tdata);
        samples_accepted++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_samples.size() != 0 && (calm || $urandom_range(99) >= IdlePct)) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= pending_samples.pop_front();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic check_subcarrier();
    subcarrier_t want;
    logic [15:0] got_re;
    logic [15:0] got_im;
    logic [7:0]  got_sc;
    got_re = m_axis_tdata[15:0];
    got_im = m_axis_tdata[31:16];
    got_sc = m_axis_tdata[39:32];
    if (expected_subcarriers.size() == 0) begin
      $error("unexpected result for subcarrier %0d", got_sc);
      mismatches++;
    end else begin
      want = expected_subcarriers.pop_front();
      results_checked++;
      if (got_re !== want.re) begin
        $error("out_re: expected %0d, got %0d", $signed(want.re), $signed(got_re));
        mismatches++;
      end
      if (got_im !== want.im) begin
        $error("out_im: expected %0d, got %0d", $signed(want.im), $signed(got_im));
        mismatches++;
      end
      if (got_sc !== want.sc) begin
        $error("subcarrier: expected %0d, got %0d", want.sc, got_sc);
        mismatches++;
      end
      if (m_axis_tlast !== want.last) begin
        $error("last_of_run: expected %0b, got %0b", want.last, m_axis_tlast);
        mismatches++;
      end
    end
  endtask

  // result monitor; a hold request stalls the output until hold_left counts down to zero
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      hold_seen     <= 0;
      hold_left     <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_subcarrier();
      if (hold_seen != hold_requests) begin
        hold_seen     <= hold_requests;
        hold_left     <= HoldCycles;
        m_axis_tready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left     <= hold_left - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= calm || ($urandom_range(99) >= IdlePct);
      end
    end
  end

  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_samples.size() != 0 || s_axis_tvalid || expected_subcarriers.size() != 0);
    // a trailing sample may cause no result yet still be in flight
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(fdsp_pkg::cfg_idx_e idx, logic [3:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == fdsp_pkg::CfgOverlap) cfg_k = val[2:0];
    else cfg_lg = val;
    sample_pos = 0;
    reg_writes++;
  endtask

  task automatic apply_setting(logic [3:0] k_val, logic [3:0] lg_val, bit wr_k, bit wr_lg);
    wait_idle();
    calm = 1'b0;
    if (wr_k) write_reg(fdsp_pkg::CfgOverlap, k_val);
    if (wr_lg) write_reg(fdsp_pkg::CfgScLog2, lg_val);
    @(negedge clk_i);
  endtask

  function automatic logic [15:0] pick_value();
    if ($urandom_range(99) < 15) begin
      case ($urandom_range(3))
        0: return 16'h7fff;
        1: return 16'h8000;
        2: return 16'h0000;
        default: return 16'hffff;
      endcase
    end
    return 16'($urandom);
  endfunction

  task automatic queue_random(int count);
    logic [15:0] re;
    logic [15:0] im;
    repeat (count) begin
      re = pick_value();
      im = pick_value();
      pending_samples.push_back({im, re});
    end
  endtask

  initial begin
    int random_pushed;
    int phase;
    int len;
    int vectors;
    int tail;
    int r;
    logic [3:0] k_val;
    logic [3:0] lg_val;

    random_pushed = 0;
    phase = 0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset settings (K=4, 256 subcarriers): full-scale samples, first interior subcarrier
    pending_samples.push_back({16'h8000, 16'h7fff});
    pending_samples.push_back({16'h7fff, 16'h8000});
    pending_samples.push_back({16'hffff, 16'h0000});
    pending_samples.push_back({16'h0000, 16'hffff});
    pending_samples.push_back({16'h7fff, 16'h7fff});
    pending_samples.push_back({16'h8000, 16'h8000});
    pending_samples.push_back({16'hfffe, 16'h0001});
    pending_samples.push_back({16'haaaa, 16'h5555});

    // single subcarrier, driven into saturation both ways
    apply_setting(4'd2, 4'd0, 1'b1, 1'b1);
    pending_samples.push_back({16'h8000, 16'h7fff});
    pending_samples.push_back({16'h8000, 16'h7fff});
    pending_samples.push_back({16'h7fff, 16'h8000});
    pending_samples.push_back({16'h7fff, 16'h8000});

    apply_setting(4'd3, 4'd1, 1'b1, 1'b1);
    queue_random(6);

    // overlap code below range acts as K=2
    apply_setting(4'd0, 4'd1, 1'b1, 1'b0);
    queue_random(4);

    while (random_pushed < RandomSamples) begin
      case (phase)
        0: begin
          // output held off while the sender keeps going
          apply_setting(4'd2, 4'd5, 1'b1, 1'b1);
          hold_requests++;
          len = 128;
          queue_random(len);
        end
        1: begin
          apply_setting(4'd4, 4'd3, 1'b1, 1'b1);
          calm = 1'b1;
          len = 64;
          queue_random(len);
        end
        2: begin
          // largest codes: K clamps to 4, log2 clamps to 8; partial vector
          apply_setting(4'd15, 4'd15, 1'b1, 1'b1);
          len = 40;
          queue_random(len);
        end
        default: begin
          r = $urandom_range(9);
          k_val = ($urandom_range(9) < 7) ? 4'($urandom_range(4, 2)) : 4'($urandom_range(15));
          case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: lg_val = 4'($urandom_range(3));
            6, 7:             lg_val = 4'($urandom_range(5, 4));
            default:          lg_val = 4'($urandom_range(15, 6));
          endcase
          apply_setting(k_val, lg_val, r != 1, r != 0);
          len = eff_overlap() << eff_lg();
          if (len <= 64) begin
            vectors = $urandom_range(3, 1);
            // sometimes cut the next vector short before the next write
            tail = ($urandom_range(3) == 0) ? $urandom_range(len - 1, 1) : 0;
          end else begin
            vectors = 0;
            tail = $urandom_range(48, 16);
          end
          len = vectors * len + tail;
          queue_random(len);
        end
      endcase
      random_pushed += len;
      phase++;
    end

    wait_idle();
    $display("Streamed %0d samples over %0d register writes; checked %0d subcarrier results.",
             samples_accepted, reg_writes, results_checked);
    $display("Overlap 2 to 4 incl. out-of-range codes, 1 to 256 subcarriers, long output stall.");
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #(TimeoutCycles * ClkPeriod);
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/fdsp_pkg.sv
design/fbmc_frequency_despreader_unit.sv
bench/tb.sv
